@@ sv/timeout_request_queue_assert.svh @@
// assertion macros for the timeout request queue checker
// depends on nothing; included by the checker file
`ifndef TIMEOUT_REQUEST_QUEUE_ASSERT_SVH
`define TIMEOUT_REQUEST_QUEUE_ASSERT_SVH

// plain clocked property with reset disable
`define TRQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// overlapping implication
`define TRQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TRQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/trq_pkg.sv @@
// types and codes shared by the timeout request queue modules
// depends on nothing
package trq_pkg;

  typedef logic [15:0] handle_t;
  typedef logic [15:0] ticks_t;
  typedef logic [4:0]  occ_t;

  typedef enum logic [1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_FETCH = 2'd1,
    FUNC_TICK  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    EV_FETCHED = 2'd0,
    EV_EMPTY   = 2'd1,
    EV_EXPIRED = 2'd2,
    EV_EVICTED = 2'd3
  } ev_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_EVICT,
    S_FETCH,
    S_WALK,
    S_FLUSH
  } state_e;

  typedef struct packed {
    logic [1:0] func;
    handle_t    handle;
    ticks_t     timeout_ticks;
  } in_t;

  typedef struct packed {
    ev_e     event_res;
    handle_t out_handle;
    logic    last;
    occ_t    occupancy;
  } out_t;

  typedef struct packed {
    handle_t handle;
    ticks_t  ticks;
  } slot_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic push_write;
    logic evict_read;
    logic evict_commit;
    logic fetch_read;
    logic fetch_commit;
    logic emit_empty;
    logic walk_start;
    logic walk_step;
    logic walk_finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] func;
    logic       full;
    logic       empty;
    logic       walk_last;
  } sts_t;

endpackage

@@ sv/timeout_request_queue.sv @@
// top level of the timeout request queue: controller plus datapath
// depends on trq_pkg, trq_ctrl, trq_dp (and trq_ram below it)
//
//   channel   ports                    handshake
//   input     in_data                  taken when start && !busy
//   result    out_data                 one cycle, marked by out_valid
//
// push goes through decode, plus an evict state when the queue is full
// (evict read); fetch goes through decode and a fetch state, decode only
// on an empty queue; a tick is decode only on an empty queue, else it walks
// the live entries one slot per cycle through the single read port of the ram
// each result is registered and shows in the cycle after the step that
// makes it; the receiver cannot stall, so results are never held back
// reset (synchronous) empties the queue; slot contents are left as they are
module timeout_request_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  trq_pkg::in_t  in_data,
  output logic          out_valid,
  output trq_pkg::out_t out_data
);

  trq_pkg::cmd_t cmd;
  trq_pkg::sts_t sts;

  trq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  trq_dp #(.DEPTH(QUEUE_DEPTH)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

@@ sv/trq_ram.sv @@
// generic single-write, single-read ram with registered read data
// depends on nothing
module trq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/trq_ctrl.sv @@
// controller state machine for the timeout request queue
// depends on trq_pkg
module trq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  trq_pkg::sts_t sts,
  output logic          busy,
  output trq_pkg::cmd_t cmd
);

  trq_pkg::state_e state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= trq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      trq_pkg::S_IDLE: begin
        if (start) state_nxt = trq_pkg::S_DECODE;
      end
      trq_pkg::S_DECODE: begin
        unique case (sts.func)
          trq_pkg::FUNC_PUSH:  state_nxt = sts.full  ? trq_pkg::S_EVICT : trq_pkg::S_IDLE;
          trq_pkg::FUNC_FETCH: state_nxt = sts.empty ? trq_pkg::S_IDLE  : trq_pkg::S_FETCH;
          trq_pkg::FUNC_TICK:  state_nxt = sts.empty ? trq_pkg::S_IDLE  : trq_pkg::S_WALK;
          default:             state_nxt = trq_pkg::S_IDLE;
        endcase
      end
      trq_pkg::S_EVICT: state_nxt = trq_pkg::S_IDLE;
      trq_pkg::S_FETCH: state_nxt = trq_pkg::S_IDLE;
      trq_pkg::S_WALK: begin
        if (sts.walk_last) state_nxt = trq_pkg::S_FLUSH;
      end
      trq_pkg::S_FLUSH: state_nxt = trq_pkg::S_IDLE;
      default: state_nxt = trq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state_r != trq_pkg::S_IDLE);
    unique case (state_r)
      trq_pkg::S_IDLE: cmd.capture = start;
      trq_pkg::S_DECODE: begin
        unique case (sts.func)
          trq_pkg::FUNC_PUSH: begin
            cmd.evict_read = sts.full;
            cmd.push_write = !sts.full;
          end
          trq_pkg::FUNC_FETCH: begin
            cmd.emit_empty = sts.empty;
            cmd.fetch_read = !sts.empty;
          end
          trq_pkg::FUNC_TICK: cmd.walk_start = !sts.empty;
          default: ;
        endcase
      end
      trq_pkg::S_EVICT: cmd.evict_commit = 1'b1;
      trq_pkg::S_FETCH: cmd.fetch_commit = 1'b1;
      trq_pkg::S_WALK:  cmd.walk_step    = 1'b1;
      trq_pkg::S_FLUSH: cmd.walk_finish  = 1'b1;
      default: ;
    endcase
  end

endmodule

@@ sv/trq_dp.sv @@
// datapath: slot ram, head/count pointers, tick walk and result register
// depends on trq_pkg and trq_ram
module trq_dp #(
  parameter int DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  trq_pkg::in_t  in_data,
  input  trq_pkg::cmd_t cmd,
  output trq_pkg::sts_t sts,
  output logic          out_valid,
  output trq_pkg::out_t out_data
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  function automatic logic [IW-1:0] inc_ptr(input logic [IW-1:0] p);
    return (p == IW'(DEPTH - 1)) ? '0 : p + IW'(1);
  endfunction

  function automatic logic [IW-1:0] add_wrap(input logic [IW-1:0] a, input logic [CW-1:0] b);
    logic [IW:0] s;
    s = {1'b0, a} + (IW+1)'(b);
    if (s >= (IW+1)'(DEPTH)) s = s - (IW+1)'(DEPTH);
    return s[IW-1:0];
  endfunction

  trq_pkg::in_t   in_r, in_nxt;
  logic [IW-1:0]  head_r, head_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [IW-1:0]  src_r, src_nxt;
  logic [IW-1:0]  dst_r, dst_nxt;
  logic [CW-1:0]  i_r, i_nxt;
  logic [CW-1:0]  w_r, w_nxt;
  logic [CW-1:0]  n_r, n_nxt;
  trq_pkg::out_t  pend_r, pend_nxt;
  logic           pend_vld_r, pend_vld_nxt;
  trq_pkg::out_t  out_r, out_nxt;
  logic           out_vld_r, out_vld_nxt;

  logic           rd_en, wr_en;
  logic [IW-1:0]  rd_addr, wr_addr;
  trq_pkg::slot_t wr_slot, rd_slot;
  logic [31:0]    rd_word;
  logic           expired;
  trq_pkg::ticks_t tk_dec;

  trq_ram #(.WIDTH($bits(trq_pkg::slot_t)), .DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_slot),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_word)
  );

  assign rd_slot = trq_pkg::slot_t'(rd_word);
  assign expired = (rd_slot.ticks == 16'd1);
  assign tk_dec  = (rd_slot.ticks != 16'd0) ? rd_slot.ticks - 16'd1 : 16'd0;

  assign sts.func      = in_r.func;
  assign sts.full      = (count_r == CW'(DEPTH));
  assign sts.empty     = (count_r == '0);
  assign sts.walk_last = (i_r == count_r - CW'(1));

  always_comb begin
    in_nxt       = in_r;
    head_nxt     = head_r;
    count_nxt    = count_r;
    src_nxt      = src_r;
    dst_nxt      = dst_r;
    i_nxt        = i_r;
    w_nxt        = w_r;
    n_nxt        = n_r;
    pend_nxt     = pend_r;
    pend_vld_nxt = pend_vld_r;
    out_nxt      = out_r;
    out_vld_nxt  = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = head_r;
    wr_en        = 1'b0;
    wr_addr      = head_r;
    wr_slot      = '{handle: in_r.handle, ticks: in_r.timeout_ticks};

    if (cmd.capture) in_nxt = in_data;

    if (cmd.push_write) begin
      wr_en     = 1'b1;
      wr_addr   = add_wrap(head_r, count_r);
      count_nxt = count_r + CW'(1);
    end

    if (cmd.evict_read || cmd.fetch_read) rd_en = 1'b1;

    // full queue: new item lands where the oldest one was
    if (cmd.evict_commit) begin
      wr_en       = 1'b1;
      head_nxt    = inc_ptr(head_r);
      out_vld_nxt = 1'b1;
      out_nxt     = '{event_res: trq_pkg::EV_EVICTED, out_handle: rd_slot.handle,
                      last: 1'b1, occupancy: trq_pkg::occ_t'(CW'(DEPTH))};
    end

    if (cmd.fetch_commit) begin
      head_nxt    = inc_ptr(head_r);
      count_nxt   = count_r - CW'(1);
      out_vld_nxt = 1'b1;
      out_nxt     = '{event_res: trq_pkg::EV_FETCHED, out_handle: rd_slot.handle,
                      last: 1'b1, occupancy: trq_pkg::occ_t'(count_r - CW'(1))};
    end

    if (cmd.emit_empty) begin
      out_vld_nxt = 1'b1;
      out_nxt     = '{event_res: trq_pkg::EV_EMPTY, out_handle: '0,
                      last: 1'b1, occupancy: '0};
    end

    if (cmd.walk_start) begin
      rd_en        = 1'b1;
      rd_addr      = head_r;
      src_nxt      = inc_ptr(head_r);
      dst_nxt      = head_r;
      i_nxt        = '0;
      w_nxt        = '0;
      n_nxt        = '0;
      pend_vld_nxt = 1'b0;
    end

    // one entry per cycle; an expired entry is held back until we know
    // whether another one follows, so last can be set on the final one
    if (cmd.walk_step) begin
      if (expired) begin
        if (pend_vld_r) begin
          out_vld_nxt = 1'b1;
          out_nxt     = pend_r;
        end
        pend_vld_nxt = 1'b1;
        pend_nxt     = '{event_res: trq_pkg::EV_EXPIRED, out_handle: rd_slot.handle,
                         last: 1'b0,
                         occupancy: trq_pkg::occ_t'(count_r - n_r - CW'(1))};
        n_nxt        = n_r + CW'(1);
      end else begin
        wr_en   = 1'b1;
        wr_addr = dst_r;
        wr_slot = '{handle: rd_slot.handle, ticks: tk_dec};
        dst_nxt = inc_ptr(dst_r);
        w_nxt   = w_r + CW'(1);
      end
      if (!sts.walk_last) begin
        rd_en   = 1'b1;
        rd_addr = src_r;
        src_nxt = inc_ptr(src_r);
      end
      i_nxt = i_r + CW'(1);
    end

    if (cmd.walk_finish) begin
      count_nxt    = w_r;
      pend_vld_nxt = 1'b0;
      if (pend_vld_r) begin
        out_vld_nxt  = 1'b1;
        out_nxt      = pend_r;
        out_nxt.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      count_r    <= '0;
      src_r      <= '0;
      dst_r      <= '0;
      i_r        <= '0;
      w_r        <= '0;
      n_r        <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      head_r     <= head_nxt;
      count_r    <= count_nxt;
      src_r      <= src_nxt;
      dst_r      <= dst_nxt;
      i_r        <= i_nxt;
      w_r        <= w_nxt;
      n_r        <= n_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r   <= in_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

@@ sv/trq_checker.sv @@
// port-level checks for the timeout request queue, bound to the top level
// depends on trq_pkg and timeout_request_queue_assert.svh
`include "timeout_request_queue_assert.svh"

module trq_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input trq_pkg::in_t  in_data,
  input logic          out_valid,
  input trq_pkg::out_t out_data
);

  logic single_ev;
  logic empty_ev;
  logic empty_ok;

  // every event but an expiry is the only result of its item
  assign single_ev = out_valid && (out_data.event_res != trq_pkg::EV_EXPIRED);
  assign empty_ev  = out_valid && (out_data.event_res == trq_pkg::EV_EMPTY);
  assign empty_ok  = (out_data.occupancy == '0) && (out_data.out_handle == '0);

  `TRQ_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted item did not raise busy")

  `TRQ_ASSERT_NXT(a_idle_quiet, clk, rst_n, !busy && !start, !out_valid, "result while idle")

  `TRQ_ASSERT_IMP(a_more_pending, clk, rst_n, out_valid && !out_data.last, busy, "non-final result while idle")

  `TRQ_ASSERT_IMP(a_single_last, clk, rst_n, single_ev, out_data.last, "single result item not marked last")

  `TRQ_ASSERT_IMP(a_empty_fields, clk, rst_n, empty_ev, empty_ok, "bad empty-queue result")

endmodule

bind timeout_request_queue trq_checker u_trq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

@@ sim/testbench.sv @@
// testbench for timeout_request_queue: push, fetch and tick items against a shadow queue
// depends on trq_pkg and the timeout_request_queue rtl
`timescale 1ns / 1ps

module testbench;

  localparam int DEPTH = 16;
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  typedef struct {
    trq_pkg::in_t op;
    bit           hold_for_drain;
    bit           may_gap;
  } send_t;

  logic          clk;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  trq_pkg::in_t  in_data = '0;
  logic          out_valid;
  trq_pkg::out_t out_data;

  send_t           pend_ops[$];
  trq_pkg::out_t   want_events[$];
  trq_pkg::slot_t  mirror[$];
  int              errors = 0;

  timeout_request_queue #(.QUEUE_DEPTH(DEPTH)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    errors++;
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
  endtask

  function automatic trq_pkg::out_t make_event(trq_pkg::ev_e ev, trq_pkg::handle_t h,
                                               logic last, trq_pkg::occ_t occ);
    trq_pkg::out_t e;
    e.event_res  = ev;
    e.out_handle = h;
    e.last       = last;
    e.occupancy  = occ;
    return e;
  endfunction

  function automatic void queue_op(logic [1:0] func, int h, int t, bit gap_ok);
    send_t s;
    s.op.func          = func;
    s.op.handle        = 16'(h);
    s.op.timeout_ticks = 16'(t);
    s.hold_for_drain   = 1'b0;
    s.may_gap          = gap_ok;
    pend_ops.push_back(s);
  endfunction

  // shadow of the queue: works out the events one accepted item causes
  task automatic apply_op(input trq_pkg::in_t op);
    trq_pkg::slot_t keep[$];
    trq_pkg::slot_t s;
    trq_pkg::out_t  e;
    int orig;
    int n;
    n = 0;
    case (op.func)
      trq_pkg::FUNC_PUSH: begin
        s.handle = op.handle;
        s.ticks  = op.timeout_ticks;
        if (mirror.size() >= DEPTH) begin
          e = make_event(trq_pkg::EV_EVICTED, mirror[0].handle, 1'b1, 5'(DEPTH));
          void'(mirror.pop_front());
          want_events.push_back(e);
        end
        mirror.push_back(s);
      end
      trq_pkg::FUNC_FETCH: begin
        if (mirror.size() == 0) begin
          want_events.push_back(make_event(trq_pkg::EV_EMPTY, '0, 1'b1, '0));
        end else begin
          s = mirror.pop_front();
          want_events.push_back(make_event(trq_pkg::EV_FETCHED, s.handle, 1'b1,
                                           5'(mirror.size())));
        end
      end
      trq_pkg::FUNC_TICK: begin
        orig = mirror.size();
        foreach (mirror[i]) begin
          s = mirror[i];
          // zero means the entry never runs out
          if (s.ticks != 0 && s.ticks - 16'd1 == 16'd0) begin
            want_events.push_back(make_event(trq_pkg::EV_EXPIRED, s.handle, 1'b0,
                                             5'(orig - n - 1)));
            n++;
          end else begin
            if (s.ticks != 0) s.ticks = s.ticks - 16'd1;
            keep.push_back(s);
          end
        end
        mirror = keep;
        if (n > 0) begin
          e = want_events.pop_back();
          e.last = 1'b1;
          want_events.push_back(e);
        end
      end
      default: begin
      end
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    logic go;
    go = 1'b0;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      // pause point: hold off until every pending event is back
      if (pend_ops.size() > 0 && pend_ops[0].hold_for_drain && !start &&
          want_events.size() == 0)
        void'(pend_ops.pop_front());
      if (pend_ops.size() > 0 && !pend_ops[0].hold_for_drain &&
          !(pend_ops[0].may_gap && $urandom_range(99) < 17)) begin
        in_data <= pend_ops[0].op;
        void'(pend_ops.pop_front());
        go = 1'b1;
      end
      start <= go;
    end
  end

  // monitor: check the result, then predict for the item taken at this edge
  always @(posedge clk) begin
    trq_pkg::out_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (want_events.size() == 0) begin
          flag_mismatch("result with nothing expected", 32'(out_data), 32'd0);
        end else begin
          want = want_events.pop_front();
          if (out_data.event_res !== want.event_res)
            flag_mismatch("event_res", 32'(out_data.event_res), 32'(want.event_res));
          if (out_data.out_handle !== want.out_handle)
            flag_mismatch("out_handle", 32'(out_data.out_handle), 32'(want.out_handle));
          if (out_data.last !== want.last)
            flag_mismatch("last", 32'(out_data.last), 32'(want.last));
          if (out_data.occupancy !== want.occupancy)
            flag_mismatch("occupancy", 32'(out_data.occupancy), 32'(want.occupancy));
        end
      end
      if (start && !busy) apply_op(in_data);
    end
  end

  initial begin
    send_t pause;
    int n_rand;
    int pick;
    int len;
    int r;
    int t;
    bit quiet;
    bit paused;

    pause.op = '0;
    pause.hold_for_drain = 1'b1;
    pause.may_gap = 1'b0;

    // directed: empty fetch, spare opcode, empty tick
    queue_op(trq_pkg::FUNC_FETCH, 16'hFFFF, 16'hFFFF, 1'b1);
    queue_op(FUNC_SPARE, 16'h1234, 16'h0001, 1'b1);
    queue_op(trq_pkg::FUNC_TICK, 0, 0, 1'b1);
    // fill the queue, overflow once, then expire all sixteen in one tick
    queue_op(trq_pkg::FUNC_PUSH, 16'h0000, 2, 1'b1);
    for (int k = 1; k < DEPTH; k++)
      queue_op(trq_pkg::FUNC_PUSH, k * 16'h1111, 1, 1'b1);
    queue_op(trq_pkg::FUNC_PUSH, 16'h5A5A, 1, 1'b1);
    queue_op(trq_pkg::FUNC_TICK, 0, 0, 1'b1);
    // never-expiring and longest timeouts
    queue_op(trq_pkg::FUNC_PUSH, 16'hFFFF, 16'h0000, 1'b1);
    queue_op(trq_pkg::FUNC_PUSH, 16'h0000, 16'hFFFF, 1'b1);
    queue_op(trq_pkg::FUNC_TICK, 0, 0, 1'b1);
    queue_op(trq_pkg::FUNC_FETCH, 0, 0, 1'b1);
    queue_op(trq_pkg::FUNC_FETCH, 0, 0, 1'b1);
    queue_op(trq_pkg::FUNC_FETCH, 0, 0, 1'b1);
    pend_ops.push_back(pause);

    n_rand = 0;
    paused = 1'b0;
    while (n_rand < 190) begin
      quiet = (n_rand >= 80 && n_rand < 140);
      pick = $urandom_range(99);
      if (pick < 45) begin
        len = $urandom_range(1, 18);
        repeat (len) begin
          r = $urandom_range(99);
          if (r < 70) t = $urandom_range(1, 5);
          else if (r < 85) t = 0;
          else t = $urandom_range(0, 65535);
          queue_op(trq_pkg::FUNC_PUSH, $urandom_range(0, 65535), t, !quiet);
          n_rand++;
        end
      end else if (pick < 75) begin
        len = $urandom_range(1, 5);
        repeat (len) begin
          queue_op(trq_pkg::FUNC_TICK, $urandom_range(0, 65535),
                   $urandom_range(0, 65535), !quiet);
          n_rand++;
        end
      end else if (pick < 93) begin
        len = $urandom_range(1, 4);
        repeat (len) begin
          queue_op(trq_pkg::FUNC_FETCH, $urandom_range(0, 65535),
                   $urandom_range(0, 65535), !quiet);
          n_rand++;
        end
      end else begin
        queue_op(FUNC_SPARE, $urandom_range(0, 65535), $urandom_range(0, 65535), !quiet);
      end
      if (n_rand >= 160 && !paused) begin
        pend_ops.push_back(pause);
        paused = 1'b1;
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (pend_ops.size() != 0 || start) @(posedge clk);
    while (want_events.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (errors == 0 && want_events.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
